FILE: src/bal_pkg.sv
// ----------------------------------------------------------------------------
// bal_pkg: shared types, constants and microcode for the balance controller
// Holds the datapath widths, the loop limits, the register map, the control
// word layout and the read-only program that sequences one control tick.
// ----------------------------------------------------------------------------
package bal_pkg;

  // loop limits
  localparam int PWM_LIMIT        = 7200;
  localparam int SPEED_TARGET_MAX = 20;
  localparam int TURN_TARGET_MAX  = 10;
  localparam int INTEGRAL_LIMIT   = 10000;
  localparam int TURN_STEP        = 30;
  localparam int GYRO_Y_OFFSET    = 4;
  localparam int LPF_NEW          = 41;
  localparam int LPF_OLD          = 215;

  // datapath widths
  localparam int MUL_W   = 18;              // multiplier operand
  localparam int PROD_W  = 2 * MUL_W;       // registered product
  localparam int ACC_W   = 44;              // accumulator
  localparam int ERR_W   = 18;              // speed error / filtered error
  localparam int INTEG_W = 15;              // clamped integral
  localparam int ISUM_W  = ERR_W + 1;       // integral before clamp
  localparam int TERM_W  = 28;              // speed, upright and turn terms
  localparam int SUM_W   = TERM_W + 2;      // motor sum before clamp
  localparam int OUT_W   = 14;              // motor drive field
  localparam int STEP_W  = 4;               // microprogram counter

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] REG_MID_ANGLE      = 3'd0;
  localparam logic [2:0] REG_UPRIGHT_KP     = 3'd1;
  localparam logic [2:0] REG_UPRIGHT_KD     = 3'd2;
  localparam logic [2:0] REG_SPEED_KP       = 3'd3;
  localparam logic [2:0] REG_SPEED_KI       = 3'd4;
  localparam logic [2:0] REG_TURN_RATE_GAIN = 3'd5;
  localparam logic [2:0] REG_TURN_CMD_GAIN  = 3'd6;

  localparam logic signed [16:0] MID_ANGLE_RST      = -17'sd2560;
  localparam logic signed [17:0] UPRIGHT_KP_RST     = -18'sd61440;
  localparam logic signed [17:0] UPRIGHT_KD_RST     = -18'sd294;
  localparam logic signed [17:0] SPEED_KP_RST       = -18'sd51200;
  localparam logic signed [17:0] SPEED_KI_RST       = -18'sd256;
  localparam logic signed [17:0] TURN_RATE_GAIN_RST = 18'sd154;
  localparam logic signed [17:0] TURN_CMD_GAIN_RST  = -18'sd7680;

  // multiplier operand pair
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_LPF_NEW,    // 41 * err
    MUL_LPF_OLD,    // 215 * filtered error
    MUL_SPD_P,      // speed_kp * filtered error
    MUL_SPD_I,      // speed_ki * integral
    MUL_UPR_P,      // upright_kp * (pitch - mid_angle)
    MUL_UPR_D,      // upright_kd * (gyro_y + 4)
    MUL_TRN_RATE,   // turn_rate_gain * gyro_z
    MUL_TRN_CMD     // turn_cmd_gain * turn target
  } mul_e;

  // accumulator operation on the registered product
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_SH8
  } acc_e;

  // writeback destination
  typedef enum logic [2:0] {
    WB_NONE,
    WB_FILT,       // filtered error <- acc / 256
    WB_INTEG,      // integral update with clamp
    WB_SPEED,      // speed term <- acc / 256
    WB_UPRIGHT,    // upright term <- acc / 65536
    WB_TURN,       // turn term <- acc / 256
    WB_OUT         // motor drives to output register
  } wb_e;

  // sequencing
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_JUMP_TURN,  // jump when a turn bit is held
    SEQ_DONE
  } seq_e;

  typedef struct packed {
    mul_e              mul;
    acc_e              acc;
    wb_e               wb;
    seq_e              seq;
    logic [STEP_W-1:0] target;
  } ucode_t;

  localparam logic [STEP_W-1:0] STEP_TURN_CMD = 4'd11;
  localparam logic [STEP_W-1:0] STEP_TURN_ACC = 4'd12;

  // Control program. The product of a step is in the product register at
  // the next step executed, where the accumulator picks it up.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{mul: MUL_NONE, acc: ACC_HOLD, wb: WB_NONE, seq: SEQ_NEXT, target: '0};
    unique case (step)
      4'd0:  w.mul = MUL_LPF_NEW;
      4'd1:  begin w.mul = MUL_LPF_OLD; w.acc = ACC_LOAD; end
      4'd2:  w.acc = ACC_ADD;
      4'd3:  w.wb  = WB_FILT;
      4'd4:  begin w.mul = MUL_SPD_P; w.wb = WB_INTEG; end
      4'd5:  begin w.mul = MUL_SPD_I; w.acc = ACC_LOAD; end
      4'd6:  begin w.mul = MUL_UPR_P; w.acc = ACC_ADD; end
      4'd7:  begin w.mul = MUL_UPR_D; w.acc = ACC_LOAD; w.wb = WB_SPEED; end
      4'd8:  w.acc = ACC_ADD_SH8;
      4'd9:  begin w.wb = WB_UPRIGHT; w.seq = SEQ_JUMP_TURN; w.target = STEP_TURN_CMD; end
      4'd10: begin w.mul = MUL_TRN_RATE; w.seq = SEQ_JUMP; w.target = STEP_TURN_ACC; end
      4'd11: w.mul = MUL_TRN_CMD;
      4'd12: w.acc = ACC_LOAD;
      4'd13: w.wb  = WB_TURN;
      4'd14: begin w.wb = WB_OUT; w.seq = SEQ_DONE; end
      default: w.seq = SEQ_DONE;
    endcase
    return w;
  endfunction

  // clamp a motor sum to +-PWM_LIMIT and take the output field bits
  function automatic logic signed [OUT_W-1:0] clamp_pwm(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] lim;
    logic signed [SUM_W-1:0] r;
    lim = SUM_W'(PWM_LIMIT);
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r[OUT_W-1:0];
  endfunction

endpackage

FILE: src/balance_robot_cascade_pid_unit.sv
// ----------------------------------------------------------------------------
// balance_robot_cascade_pid_unit: two-wheel balance controller
// Upright PD, speed PI and turn loops, sequenced by a microprogram over one
// shared 18x18 multiplier and a wide accumulator; one item per control tick.
//
//   channel   dir   handshake                  payload
//   in        in    in_valid_i / in_stall_o    encoders, pitch, gyros, cmd bits
//   out       out   out_valid_o / out_stall_i  motor_left_o, motor_right_o
//   cfg       in    APB psel/penable/pready    seven gain and offset registers
//
// An item runs from the accept through 14 microprogram steps on either
// side of the turn jump, set by the seven products that go one after
// another through the single multiplier; the input stalls while they run.
// The last step loads the result. Reset restores the register defaults and
// clears the loop state. A new item is taken while a result waits in the
// output register; the last step holds until that register is free.
// ----------------------------------------------------------------------------
module balance_robot_cascade_pid_unit
  import bal_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [15:0]           enc_left_raw_i,
  input  logic signed [15:0]           enc_right_i,
  input  logic signed [16:0]           pitch_i,
  input  logic signed [15:0]           gyro_y_i,
  input  logic signed [15:0]           gyro_z_i,
  input  logic                         fore_i,
  input  logic                         back_i,
  input  logic                         turn_left_i,
  input  logic                         turn_right_i,
  input  logic                         clear_integral_i,
  // result items
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [OUT_W-1:0]      motor_left_o,
  output logic signed [OUT_W-1:0]      motor_right_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_ADDR_W-1:0]        paddr,
  input  logic [CFG_DATA_W-1:0]        pwdata,
  output logic [CFG_DATA_W-1:0]        prdata,
  output logic                         pready
);

  localparam logic signed [6:0]  ST_MAX  = 7'(SPEED_TARGET_MAX);
  localparam logic signed [7:0]  TT_MAX  = 8'(TURN_TARGET_MAX);
  localparam logic signed [7:0]  TT_STEP = 8'(TURN_STEP);
  localparam logic signed [ISUM_W-1:0]  ISUM_LIM = ISUM_W'(INTEGRAL_LIMIT);
  localparam logic signed [INTEG_W-1:0] INTEG_LIM = INTEG_W'(INTEGRAL_LIMIT);
  localparam logic signed [OUT_W-1:0]   OUT_LIM = OUT_W'(PWM_LIMIT);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [16:0] mid_angle_q;
  logic signed [17:0] upright_kp_q, upright_kd_q, speed_kp_q, speed_ki_q;
  logic signed [17:0] turn_rate_gain_q, turn_cmd_gain_q;
  logic               cfg_we;
  logic [2:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_angle_q      <= MID_ANGLE_RST;
      upright_kp_q     <= UPRIGHT_KP_RST;
      upright_kd_q     <= UPRIGHT_KD_RST;
      speed_kp_q       <= SPEED_KP_RST;
      speed_ki_q       <= SPEED_KI_RST;
      turn_rate_gain_q <= TURN_RATE_GAIN_RST;
      turn_cmd_gain_q  <= TURN_CMD_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MID_ANGLE:      mid_angle_q      <= pwdata[16:0];
        REG_UPRIGHT_KP:     upright_kp_q     <= pwdata[17:0];
        REG_UPRIGHT_KD:     upright_kd_q     <= pwdata[17:0];
        REG_SPEED_KP:       speed_kp_q       <= pwdata[17:0];
        REG_SPEED_KI:       speed_ki_q       <= pwdata[17:0];
        REG_TURN_RATE_GAIN: turn_rate_gain_q <= pwdata[17:0];
        REG_TURN_CMD_GAIN:  turn_cmd_gain_q  <= pwdata[17:0];
        default: ;  // no register here
      endcase
    end
  end

  // register readback, sign extended
  always_comb begin
    unique case (cfg_idx)
      REG_MID_ANGLE:      prdata = CFG_DATA_W'(mid_angle_q);
      REG_UPRIGHT_KP:     prdata = CFG_DATA_W'(upright_kp_q);
      REG_UPRIGHT_KD:     prdata = CFG_DATA_W'(upright_kd_q);
      REG_SPEED_KP:       prdata = CFG_DATA_W'(speed_kp_q);
      REG_SPEED_KI:       prdata = CFG_DATA_W'(speed_ki_q);
      REG_TURN_RATE_GAIN: prdata = CFG_DATA_W'(turn_rate_gain_q);
      REG_TURN_CMD_GAIN:  prdata = CFG_DATA_W'(turn_cmd_gain_q);
      default:            prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // item accept: target ramps and operand preparation
  // --------------------------------------------------------------------------
  logic                     busy_q;
  logic                     in_acc;
  logic signed [5:0]        speed_target_q, speed_target_d;
  logic signed [4:0]        turn_target_q, turn_target_d;
  logic signed [5:0]        st_hold;
  logic signed [4:0]        tt_hold;
  logic signed [6:0]        st_sum;
  logic signed [7:0]        tt_sum;
  logic signed [ERR_W-1:0]  err_d, err_q;
  logic signed [17:0]       diff_d, diff_q;
  logic signed [16:0]       gyp_d, gyp_q;
  logic signed [15:0]       gz_q;
  logic                     turning_q, clr_q;

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !busy_q;

  always_comb begin
    // speed target: drop to zero with no drive bit, then step and clamp
    st_hold = (fore_i || back_i) ? speed_target_q : '0;
    st_sum  = {st_hold[5], st_hold};
    if (fore_i) st_sum = st_sum + 7'sd1;
    if (back_i) st_sum = st_sum - 7'sd1;
    if (st_sum > ST_MAX) st_sum = ST_MAX;
    else if (st_sum < -ST_MAX) st_sum = -ST_MAX;
    speed_target_d = st_sum[5:0];

    // turn target, same pattern with a step of TURN_STEP
    tt_hold = (turn_left_i || turn_right_i) ? turn_target_q : '0;
    tt_sum  = {{3{tt_hold[4]}}, tt_hold};
    if (turn_left_i)  tt_sum = tt_sum + TT_STEP;
    if (turn_right_i) tt_sum = tt_sum - TT_STEP;
    if (tt_sum > TT_MAX) tt_sum = TT_MAX;
    else if (tt_sum < -TT_MAX) tt_sum = -TT_MAX;
    turn_target_d = tt_sum[4:0];

    // wheel speed error against the new target (left encoder negated)
    err_d = {{2{enc_right_i[15]}}, enc_right_i}
          - {{2{enc_left_raw_i[15]}}, enc_left_raw_i}
          - {{12{speed_target_d[5]}}, speed_target_d};
    diff_d = {pitch_i[16], pitch_i} - {mid_angle_q[16], mid_angle_q};
    gyp_d  = {gyro_y_i[15], gyro_y_i} + 17'(GYRO_Y_OFFSET);
  end

  // --------------------------------------------------------------------------
  // microprogram sequencer
  // --------------------------------------------------------------------------
  logic [STEP_W-1:0] step_q;
  ucode_t            cw;
  logic              out_valid_q;
  logic              out_blocked;
  logic              adv;

  assign cw          = ucode_rom(step_q);
  assign out_blocked = (cw.wb == WB_OUT) && out_valid_q && out_stall_i;
  assign adv         = busy_q && !out_blocked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (in_acc) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (adv) begin
      unique case (cw.seq)
        SEQ_NEXT:      step_q <= step_q + STEP_W'(1);
        SEQ_JUMP:      step_q <= cw.target;
        SEQ_JUMP_TURN: step_q <= turning_q ? cw.target : step_q + STEP_W'(1);
        SEQ_DONE:      busy_q <= 1'b0;
        default:       busy_q <= 1'b0;
      endcase
    end
  end

  // loop state and operand registers loaded at accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_target_q <= '0;
      turn_target_q  <= '0;
    end else if (in_acc) begin
      speed_target_q <= speed_target_d;
      turn_target_q  <= turn_target_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      err_q     <= err_d;
      diff_q    <= diff_d;
      gyp_q     <= gyp_d;
      gz_q      <= gyro_z_i;
      turning_q <= turn_left_i || turn_right_i;
      clr_q     <= clear_integral_i;
    end
  end

  // --------------------------------------------------------------------------
  // shared multiplier with product register
  // --------------------------------------------------------------------------
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ERR_W-1:0]  fe_q;
  logic signed [INTEG_W-1:0] integ_q;

  always_comb begin
    unique case (cw.mul)
      MUL_LPF_NEW:  begin mul_a = MUL_W'(LPF_NEW);  mul_b = err_q; end
      MUL_LPF_OLD:  begin mul_a = MUL_W'(LPF_OLD);  mul_b = fe_q; end
      MUL_SPD_P:    begin mul_a = speed_kp_q;       mul_b = fe_q; end
      MUL_SPD_I:    begin
        mul_a = speed_ki_q;
        mul_b = {{(MUL_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q};
      end
      MUL_UPR_P:    begin mul_a = upright_kp_q;     mul_b = diff_q; end
      MUL_UPR_D:    begin mul_a = upright_kd_q;     mul_b = {gyp_q[16], gyp_q}; end
      MUL_TRN_RATE: begin mul_a = turn_rate_gain_q; mul_b = {{2{gz_q[15]}}, gz_q}; end
      MUL_TRN_CMD:  begin
        mul_a = turn_cmd_gain_q;
        mul_b = {{(MUL_W-5){turn_target_q[4]}}, turn_target_q};
      end
      default:      begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // 18x18 signed operands, sign extended to the product width
  always_ff @(posedge clk_i) begin
    if (adv) prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // --------------------------------------------------------------------------
  // accumulator and truncating scale-down
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc_q, prod_ext, bias, rnd, quo;

  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      unique case (cw.acc)
        ACC_LOAD:    acc_q <= prod_ext;
        ACC_ADD:     acc_q <= acc_q + prod_ext;
        ACC_ADD_SH8: acc_q <= acc_q + (prod_ext <<< 8);
        default:     acc_q <= acc_q;
      endcase
    end
  end

  // divide by 256 or 65536, rounding toward zero
  always_comb begin
    bias = (cw.wb == WB_UPRIGHT) ? ACC_W'(17'h0FFFF) : ACC_W'(17'h000FF);
    rnd  = acc_q + (acc_q[ACC_W-1] ? bias : '0);
    quo  = (cw.wb == WB_UPRIGHT) ? (rnd >>> 16) : (rnd >>> 8);
  end

  // --------------------------------------------------------------------------
  // writeback: filter, integral, loop terms
  // --------------------------------------------------------------------------
  logic signed [ISUM_W-1:0] isum, iclamp;
  logic signed [TERM_W-1:0] speed_term_q, upright_term_q, turn_term_q;

  always_comb begin
    isum = {{(ISUM_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q} + {fe_q[ERR_W-1], fe_q};
    if (isum >= ISUM_LIM) iclamp = ISUM_LIM;
    else if (isum < -ISUM_LIM) iclamp = -ISUM_LIM;
    else iclamp = isum;
    if (clr_q) iclamp = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_q    <= '0;
      integ_q <= '0;
    end else if (adv) begin
      if (cw.wb == WB_FILT)  fe_q    <= quo[ERR_W-1:0];
      if (cw.wb == WB_INTEG) integ_q <= iclamp[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (cw.wb == WB_SPEED)   speed_term_q   <= quo[TERM_W-1:0];
      if (cw.wb == WB_UPRIGHT) upright_term_q <= quo[TERM_W-1:0];
      if (cw.wb == WB_TURN)    turn_term_q    <= quo[TERM_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // motor mix and output register
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0]  base, sum_l, sum_r;
  logic signed [OUT_W-1:0]  motor_left_q, motor_right_q;
  logic                     out_load;

  assign base     = SUM_W'(upright_term_q) + SUM_W'(speed_term_q);
  assign sum_l    = base - SUM_W'(turn_term_q);
  assign sum_r    = base + SUM_W'(turn_term_q);
  assign out_load = adv && (cw.wb == WB_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      motor_left_q  <= clamp_pwm(sum_l);
      motor_right_q <= clamp_pwm(sum_r);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign motor_left_o  = motor_left_q;
  assign motor_right_o = motor_right_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("output register loaded while a result waits");

  // an accepted item starts the program at its first step
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (busy_q && step_q == '0))
    else $error("program did not start at step zero");

  // integral stays inside its clamp
  a_integ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q <= INTEG_LIM) && (integ_q >= -INTEG_LIM))
    else $error("speed integral out of range");

  // ramped targets stay inside their clamps
  a_targets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (speed_target_q <= 6'(SPEED_TARGET_MAX)) && (speed_target_q >= -6'(SPEED_TARGET_MAX))
    && (turn_target_q <= 5'(TURN_TARGET_MAX)) && (turn_target_q >= -5'(TURN_TARGET_MAX)))
    else $error("drive target out of range");

  // delivered drives respect the PWM limit
  a_pwm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((motor_left_o <= OUT_LIM) && (motor_left_o >= -OUT_LIM)
                     && (motor_right_o <= OUT_LIM) && (motor_right_o >= -OUT_LIM)))
    else $error("motor drive beyond PWM limit");

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the two-wheel balance controller
// A directed table (reset values, sensor extremes, drive, turn and clear patterns,
// integral clamp and clear) is followed by random control ticks. The ticks
// come as held drive commands over several gain settings, with idle and stall
// bursts on both channels. Every motor drive is checked against a cycle-free
// model of the upright, speed and turn loops.
// ----------------------------------------------------------------------------
module testbench;
  import bal_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_TICKS   = 165;
  localparam int NUM_PHASES    = 6;
  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_PRINTS    = 30;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // command bit patterns {fore, back, turn_left, turn_right, clear_integral}
  localparam logic [4:0] CMD_NONE  = 5'b00000;
  localparam logic [4:0] CMD_FORE  = 5'b10000;
  localparam logic [4:0] CMD_BACK  = 5'b01000;
  localparam logic [4:0] CMD_LEFT  = 5'b00100;
  localparam logic [4:0] CMD_RIGHT = 5'b00010;
  localparam logic [4:0] CMD_CLEAR = 5'b00001;

  typedef struct {
    logic signed [15:0] enc_l;
    logic signed [15:0] enc_r;
    logic signed [16:0] pitch;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [4:0]         cmd;
  } tick_t;

  typedef struct {
    logic signed [OUT_W-1:0] left;
    logic signed [OUT_W-1:0] right;
  } drive_t;

  typedef struct {
    tick_t  tick;
    bit     known;
    drive_t drive;
  } dir_row_t;

  // DUT ports
  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic signed [15:0]    enc_left_raw_i = '0;
  logic signed [15:0]    enc_right_i = '0;
  logic signed [16:0]    pitch_i = '0;
  logic signed [15:0]    gyro_y_i = '0;
  logic signed [15:0]    gyro_z_i = '0;
  logic                  fore_i = 1'b0;
  logic                  back_i = 1'b0;
  logic                  turn_left_i = 1'b0;
  logic                  turn_right_i = 1'b0;
  logic                  clear_integral_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] motor_left_o;
  logic signed [OUT_W-1:0] motor_right_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  balance_robot_cascade_pid_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .enc_left_raw_i   (enc_left_raw_i),
    .enc_right_i      (enc_right_i),
    .pitch_i          (pitch_i),
    .gyro_y_i         (gyro_y_i),
    .gyro_z_i         (gyro_z_i),
    .fore_i           (fore_i),
    .back_i           (back_i),
    .turn_left_i      (turn_left_i),
    .turn_right_i     (turn_right_i),
    .clear_integral_i (clear_integral_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .motor_left_o     (motor_left_o),
    .motor_right_o    (motor_right_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // bench state
  drive_t   pending_drives[$];
  dir_row_t directed_ticks[$];
  int       mismatch_count = 0;
  int       ticks_sent = 0;
  int       drives_seen = 0;
  int       cycle_count = 0;
  bit       idle_on = 1'b1;
  int       stall_left = 0;

  // loop model state and register copy
  longint gain_val[7];
  longint speed_tgt = 0;
  longint turn_tgt = 0;
  longint filt_err = 0;
  longint err_sum = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d drives outstanding", cycle_count,
             pending_drives.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint sign_ext(input logic [31:0] v, input int w);
    longint x;
    x = longint'(v) & ((longint'(1) << w) - 1);
    if (x[w-1]) x -= longint'(1) << w;
    return x;
  endfunction

  function automatic longint clamp_to(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // one control tick of the cascade: ramps, filter, integral, three loops
  function automatic drive_t predict_drive(input tick_t t);
    logic   fore, back, tl, tr, clr;
    longint err, spd, upr, trn, base, ml, mr;
    drive_t d;
    {fore, back, tl, tr, clr} = t.cmd;

    if (!fore && !back) speed_tgt = 0;
    if (fore) speed_tgt += 1;
    if (back) speed_tgt -= 1;
    speed_tgt = clamp_to(speed_tgt, longint'(SPEED_TARGET_MAX));

    if (!tl && !tr) turn_tgt = 0;
    if (tl) turn_tgt += TURN_STEP;
    if (tr) turn_tgt -= TURN_STEP;
    turn_tgt = clamp_to(turn_tgt, longint'(TURN_TARGET_MAX));

    // filtered wheel speed error and its clamped integral
    err = -longint'(t.enc_l) + longint'(t.enc_r) - speed_tgt;
    filt_err = (LPF_NEW * err + LPF_OLD * filt_err) / 256;
    err_sum += filt_err;
    if (err_sum >= INTEGRAL_LIMIT) err_sum = INTEGRAL_LIMIT;
    if (err_sum < -INTEGRAL_LIMIT) err_sum = -INTEGRAL_LIMIT;
    if (clr) err_sum = 0;

    spd = (gain_val[REG_SPEED_KP] * filt_err + gain_val[REG_SPEED_KI] * err_sum) / 256;
    upr = (gain_val[REG_UPRIGHT_KP] * (longint'(t.pitch) - gain_val[REG_MID_ANGLE])
           + 256 * gain_val[REG_UPRIGHT_KD] * (longint'(t.gyro_y) + GYRO_Y_OFFSET)) / 65536;
    if (!tl && !tr) trn = (gain_val[REG_TURN_RATE_GAIN] * longint'(t.gyro_z)) / 256;
    else trn = (gain_val[REG_TURN_CMD_GAIN] * turn_tgt) / 256;

    base = upr + spd;
    ml = clamp_to(base - trn, longint'(PWM_LIMIT));
    mr = clamp_to(base + trn, longint'(PWM_LIMIT));
    d.left  = ml[OUT_W-1:0];
    d.right = mr[OUT_W-1:0];
    return d;
  endfunction

  function automatic dir_row_t mk_row(input int el, input int er, input int p, input int gy,
                                      input int gz, input logic [4:0] cmd,
                                      input bit known = 1'b0, input int ml = 0,
                                      input int mr = 0);
    dir_row_t r;
    r.tick = '{enc_l: el[15:0], enc_r: er[15:0], pitch: p[16:0], gyro_y: gy[15:0],
               gyro_z: gz[15:0], cmd: cmd};
    r.known = known;
    r.drive = '{left: ml[OUT_W-1:0], right: mr[OUT_W-1:0]};
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("mismatch at cycle %0d, drive %0d: %s got %0d expected %0d",
               cycle_count, drives_seen, field, got, want);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx != REG_UNUSED)
      gain_val[idx] = sign_ext(data, (idx == REG_MID_ANGLE) ? 17 : 18);
    @(posedge clk_i);
  endtask

  // offer one tick, wait for it to be taken, queue its expected drives
  task automatic send_tick(input tick_t t, input bit known, input drive_t typed);
    drive_t d;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    enc_left_raw_i   <= t.enc_l;
    enc_right_i      <= t.enc_r;
    pitch_i          <= t.pitch;
    gyro_y_i         <= t.gyro_y;
    gyro_z_i         <= t.gyro_z;
    {fore_i, back_i, turn_left_i, turn_right_i, clear_integral_i} <= t.cmd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    d = predict_drive(t);
    pending_drives.push_back(known ? typed : d);
    ticks_sent++;
  endtask

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // result side: random stall bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    drive_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_drives.size() == 0) begin
        report_mismatch("unexpected drive, motor_left", int'(motor_left_o), 0);
      end else begin
        want = pending_drives.pop_front();
        if (motor_left_o !== want.left)
          report_mismatch("motor_left", int'(motor_left_o), int'(want.left));
        if (motor_right_o !== want.right)
          report_mismatch("motor_right", int'(motor_right_o), int'(want.right));
      end
      drives_seen++;
    end
  end

  initial begin
    tick_t      t;
    drive_t     none;
    logic [4:0] held;
    int         hold_left;
    int         roll;

    none = '{left: '0, right: '0};
    gain_val[REG_MID_ANGLE]      = longint'(MID_ANGLE_RST);
    gain_val[REG_UPRIGHT_KP]     = longint'(UPRIGHT_KP_RST);
    gain_val[REG_UPRIGHT_KD]     = longint'(UPRIGHT_KD_RST);
    gain_val[REG_SPEED_KP]       = longint'(SPEED_KP_RST);
    gain_val[REG_SPEED_KI]       = longint'(SPEED_KI_RST);
    gain_val[REG_TURN_RATE_GAIN] = longint'(TURN_RATE_GAIN_RST);
    gain_val[REG_TURN_CMD_GAIN]  = longint'(TURN_CMD_GAIN_RST);

    // directed ticks: enc_l, enc_r, pitch, gyro_y, gyro_z, commands
    directed_ticks.push_back(mk_row(0, 0, 0, 0, 0, CMD_NONE, 1, -2404, -2404));
    directed_ticks.push_back(mk_row(0, 0, -65536, 0, 0, CMD_NONE, 1, 7200, 7200));
    directed_ticks.push_back(mk_row(0, 0, 65535, 0, 0, CMD_NONE, 1, -7200, -7200));
    // level at the balance angle with the gyro offset cancelled
    directed_ticks.push_back(mk_row(0, 0, -2560, -4, 0, CMD_NONE, 1, 0, 0));
    directed_ticks.push_back(mk_row(0, 0, 46080, 32767, -32768, CMD_NONE));
    directed_ticks.push_back(mk_row(0, 0, -46080, -32768, 32767, CMD_NONE));
    directed_ticks.push_back(mk_row(3, -3, 100, 50, 20, CMD_FORE));
    directed_ticks.push_back(mk_row(3, -3, 100, 50, 20, CMD_FORE));
    directed_ticks.push_back(mk_row(3, -3, 100, 50, 20, CMD_FORE | CMD_BACK));
    directed_ticks.push_back(mk_row(-2, 5, -200, -60, 7, CMD_BACK));
    directed_ticks.push_back(mk_row(-2, 5, -200, -60, 7, CMD_BACK));
    directed_ticks.push_back(mk_row(0, 0, 0, 0, 900, CMD_LEFT));
    directed_ticks.push_back(mk_row(0, 0, 0, 0, 900, CMD_RIGHT));
    directed_ticks.push_back(mk_row(0, 0, 0, 0, 900, CMD_LEFT | CMD_RIGHT));
    directed_ticks.push_back(mk_row(0, 0, 0, 0, -32768, CMD_LEFT));
    // full-scale wheel error drives the integral into both clamps
    directed_ticks.push_back(mk_row(-32768, 32767, 0, 0, 0, CMD_NONE));
    directed_ticks.push_back(mk_row(-32768, 32767, 0, 0, 0, CMD_NONE));
    directed_ticks.push_back(mk_row(32767, -32768, 0, 0, 0, CMD_NONE));
    directed_ticks.push_back(mk_row(32767, -32768, 0, 0, 0, CMD_NONE));
    directed_ticks.push_back(mk_row(32767, -32768, 0, 0, 0, CMD_CLEAR));
    directed_ticks.push_back(mk_row(-32768, -32768, 0, 0, 0, CMD_FORE | CMD_CLEAR));
    directed_ticks.push_back(mk_row(-1, -1, -1, 16'h5555, 16'haaaa, 5'b11111));
    directed_ticks.push_back(mk_row(0, 0, 0, 16'haaaa, 16'h5555, CMD_NONE));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_ticks[i])
      send_tick(directed_ticks[i].tick, directed_ticks[i].known, directed_ticks[i].drive);

    held = CMD_NONE;
    hold_left = 0;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_and_settle();
      idle_on = (phase != NUM_PHASES - 1);
      case (phase)
        1: begin
          cfg_write(REG_MID_ANGLE, 32'd46080);
          for (int r = 1; r < 7; r++) cfg_write(r[2:0], 32'd131071);
        end
        2: begin
          cfg_write(REG_MID_ANGLE, -32'sd46080);
          for (int r = 1; r < 7; r++) cfg_write(r[2:0], -32'sd131072);
        end
        3: begin
          for (int r = 0; r < 7; r++) cfg_write(r[2:0], $urandom());
        end
        4: begin
          cfg_write(REG_MID_ANGLE, $urandom_range(0, 92160) - 46080);
          for (int r = 1; r < 7; r++) cfg_write(r[2:0], $urandom_range(0, 262143) - 131072);
          cfg_write(REG_UNUSED, $urandom());
        end
        5: begin
          cfg_write(REG_MID_ANGLE, 32'(MID_ANGLE_RST));
          cfg_write(REG_UPRIGHT_KP, 32'(UPRIGHT_KP_RST));
          cfg_write(REG_UPRIGHT_KD, 32'(UPRIGHT_KD_RST));
          cfg_write(REG_SPEED_KP, 32'(SPEED_KP_RST));
          cfg_write(REG_SPEED_KI, 32'(SPEED_KI_RST));
          cfg_write(REG_TURN_RATE_GAIN, 32'(TURN_RATE_GAIN_RST));
          cfg_write(REG_TURN_CMD_GAIN, 32'(TURN_CMD_GAIN_RST));
        end
        default: ;
      endcase

      for (int n = 0; n < PHASE_TICKS; n++) begin
        // drive commands are held for runs so the ramps reach their clamps
        if (hold_left == 0) begin
          roll = $urandom_range(0, 9);
          case (roll)
            0, 1:    held = CMD_NONE;
            2, 3:    held = CMD_FORE;
            4, 5:    held = CMD_BACK;
            6:       held = CMD_LEFT;
            7:       held = CMD_RIGHT;
            8:       held = {CMD_FORE[4], $urandom_range(0, 1) == 1, 2'b11, 1'b0} |
                            CMD_LEFT;
            default: held = CMD_FORE | CMD_BACK | ($urandom_range(0, 1) ? CMD_LEFT : CMD_NONE);
          endcase
          hold_left = $urandom_range(1, 30);
        end
        hold_left--;
        t.cmd = held | (($urandom_range(0, 15) == 0) ? CMD_CLEAR : CMD_NONE);
        if ($urandom_range(0, 15) == 0)
          t.cmd = 5'($urandom());
        if ($urandom_range(0, 7) == 0) begin
          t.enc_l  = 16'($urandom());
          t.enc_r  = 16'($urandom());
          t.pitch  = 17'($urandom());
          t.gyro_y = 16'($urandom());
          t.gyro_z = 16'($urandom());
        end else begin
          t.enc_l  = 16'($urandom_range(0, 400) - 200);
          t.enc_r  = 16'($urandom_range(0, 400) - 200);
          t.pitch  = 17'($urandom_range(0, 20000) - 12560);
          t.gyro_y = 16'($urandom_range(0, 4000) - 2000);
          t.gyro_z = 16'($urandom_range(0, 4000) - 2000);
        end
        send_tick(t, 1'b0, none);
      end
    end

    drain_and_settle();
    $display("%0d control ticks (%0d directed) checked as %0d motor drive pairs",
             ticks_sent, directed_ticks.size(), drives_seen);
    $display("over %0d gain settings, with command ramps, integral clamps and stalls",
             NUM_PHASES);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
